>>> rtl/pfs_pkg.sv
// ----------------------------------------------------------------------------
// pfs_pkg
// Field widths, register indexes and register reset values for the parallel
// formant synthesizer.
// ----------------------------------------------------------------------------
package pfs_pkg;

    // Fixed field widths
    localparam int N_W        = 10;  // period length
    localparam int B_W        = 18;  // resonator B, signed Q2.16
    localparam int D_W        = 24;  // resonator D, signed Q16.8
    localparam int C_W        = 16;  // resonator C, unsigned Q0.16
    localparam int GAIN_W     = 15;  // excitation peak, unsigned Q0.15
    localparam int SAMPLE_W   = 16;  // output sample
    localparam int STATE_W    = 32;  // resonator delay state
    localparam int COEF_N     = 4;   // resonators with coefficient ports
    localparam int CIDX_W     = 2;   // index into the decay registers
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DECAY_FIRST   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DECAY_SECOND  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DECAY_THIRD   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DECAY_FOURTH  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PULSE_GAIN    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_GLOTTAL_SHAPE = 3'd5;

    // Glottal shape codes
    localparam logic SHAPE_TRIANGLE = 1'b0;
    localparam logic SHAPE_IMPULSE  = 1'b1;

    // Reset values
    localparam logic [C_W-1:0] DECAY_RST [COEF_N] =
        '{16'd64609, 16'd64242, 16'd63513, 16'd61906};
    localparam logic [GAIN_W-1:0] GAIN_RST  = 15'd8192;
    localparam logic              SHAPE_RST = SHAPE_IMPULSE;

    // Payload types
    typedef logic signed [B_W-1:0]     coef_b_t;
    typedef logic signed [D_W-1:0]     coef_d_t;
    typedef logic signed [STATE_W-1:0] res_state_t;

endpackage

>>> rtl/parallel_formant_synthesizer.sv
// ----------------------------------------------------------------------------
// parallel_formant_synthesizer
// Glottal excitation driving up to four second-order resonators in parallel,
// one saturated 16-bit sample per input item.
// ----------------------------------------------------------------------------
// Usage: each input item is one sample tick and yields exactly one sample.
// The block takes one item at a time; s_ready is high only while it is idle.
// All arithmetic goes through one shared 32x25 signed multiplier under a small
// sequencer: four steps per resonator (multiplier passes B*recent, C*older
// and D*new older, then the accumulate). A triangle item inside its rising or
// falling slope also runs a restoring divider, one quotient bit per cycle over
// 25 bits. A result still waiting on m_ready holds the final step until it is
// taken. Registers are written through the cfg_ channel, which is always
// ready; write them only while the block is idle.
// ----------------------------------------------------------------------------
module parallel_formant_synthesizer #(
    parameter int NUM_RESONATORS = 4,
    parameter int MAX_PERIOD     = 1023
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // input items
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic                               s_period_start,
    input  logic [pfs_pkg::N_W-1:0]            s_period_length,
    input  logic signed [pfs_pkg::B_W-1:0]     s_coef_b_first,
    input  logic signed [pfs_pkg::B_W-1:0]     s_coef_b_second,
    input  logic signed [pfs_pkg::B_W-1:0]     s_coef_b_third,
    input  logic signed [pfs_pkg::B_W-1:0]     s_coef_b_fourth,
    input  logic signed [pfs_pkg::D_W-1:0]     s_coef_d_first,
    input  logic signed [pfs_pkg::D_W-1:0]     s_coef_d_second,
    input  logic signed [pfs_pkg::D_W-1:0]     s_coef_d_third,
    input  logic signed [pfs_pkg::D_W-1:0]     s_coef_d_fourth,
    // result items
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic signed [pfs_pkg::SAMPLE_W-1:0] m_sample,
    // configuration writes
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [pfs_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [pfs_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import pfs_pkg::*;

    localparam int ACTIVE  = (NUM_RESONATORS < COEF_N) ? NUM_RESONATORS : COEF_N;
    localparam int RIDX_W  = (ACTIVE > 1) ? $clog2(ACTIVE) : 1;
    localparam int POS_W   = $clog2(MAX_PERIOD + 1);
    localparam int CMP_W   = (POS_W > N_W) ? POS_W : N_W;
    localparam int MULA_W  = STATE_W;
    localparam int MULB_W  = D_W + 1;
    localparam int PROD_W  = MULA_W + MULB_W;
    localparam int RND_W   = PROD_W - 16;
    localparam int SUM_W   = RND_W + 2;
    localparam int ACC_W   = PROD_W + 2;
    localparam int K_W     = N_W;
    localparam int DIVR_W  = N_W - 1;
    localparam int DIVN_W  = GAIN_W + K_W;
    localparam int DCNT_W  = $clog2(DIVN_W);
    localparam int OUT_SH  = 23;

    localparam logic signed [PROD_W-1:0] RND_HALF =
        $signed({{(PROD_W-16){1'b0}}, 1'b1, 15'b0});
    localparam logic signed [ACC_W-1:0] OUT_HALF =
        $signed({{(ACC_W-OUT_SH){1'b0}}, 1'b1, {(OUT_SH-1){1'b0}}});

    typedef enum logic [3:0] {
        S_IDLE, S_EXC, S_GMUL, S_DIV, S_RB, S_RC, S_RN, S_RA, S_OUT
    } state_t;

    // registers
    state_t                   state_reg, state_next;
    logic [RIDX_W-1:0]        r_reg, r_next;
    logic [POS_W-1:0]         period_position_reg, period_position_next;
    logic [POS_W-1:0]         pos_reg, pos_next;
    logic [N_W-1:0]           n_reg, n_next;
    coef_b_t                  b_reg [ACTIVE];
    coef_b_t                  b_next [ACTIVE];
    coef_d_t                  d_reg [ACTIVE];
    coef_d_t                  d_next [ACTIVE];
    res_state_t               recent_reg [ACTIVE];
    res_state_t               recent_next [ACTIVE];
    res_state_t               older_reg [ACTIVE];
    res_state_t               older_next [ACTIVE];
    logic [C_W-1:0]           decay_reg [COEF_N];
    logic [C_W-1:0]           decay_next [COEF_N];
    logic [GAIN_W-1:0]        gain_reg, gain_next;
    logic                     shape_reg, shape_next;
    logic [GAIN_W-1:0]        x_reg, x_next;
    logic [K_W-1:0]           k_reg, k_next;
    logic [DIVR_W-1:0]        div_reg, div_next;
    logic                     falling_reg, falling_next;
    logic [DIVN_W-1:0]        num_reg, num_next;
    logic [DIVR_W-1:0]        rem_reg, rem_next;
    logic [DCNT_W-1:0]        cnt_reg, cnt_next;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic signed [RND_W-1:0]  t1_reg, t1_next;
    logic signed [ACC_W-1:0]  acc_reg, acc_next;
    logic                     m_valid_reg, m_valid_next;
    logic signed [SAMPLE_W-1:0] m_sample_reg, m_sample_next;

    // shared multiplier
    logic signed [MULA_W-1:0] mul_a;
    logic signed [MULB_W-1:0] mul_b;
    logic signed [PROD_W-1:0] mul_p;

    coef_b_t b_in [COEF_N];
    coef_d_t d_in [COEF_N];

    assign b_in = '{s_coef_b_first, s_coef_b_second, s_coef_b_third, s_coef_b_fourth};
    assign d_in = '{s_coef_d_first, s_coef_d_second, s_coef_d_third, s_coef_d_fourth};

    assign s_ready   = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_sample  = m_sample_reg;

    // product rounded to nearest at a shift of 16, halves upwards
    function automatic logic signed [RND_W-1:0] rnd16(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] q;
        q = p + RND_HALF;
        return $signed(q[PROD_W-1:16]);
    endfunction

    // operand selection for the shared multiplier
    always_comb begin
        case (state_reg)
            S_GMUL: begin
                mul_a = $signed({{(MULA_W-GAIN_W){1'b0}}, gain_reg});
                mul_b = $signed({{(MULB_W-K_W){1'b0}}, k_reg});
            end
            S_RB: begin
                mul_a = recent_reg[r_reg];
                mul_b = MULB_W'(b_reg[r_reg]);
            end
            S_RC: begin
                mul_a = older_reg[r_reg];
                mul_b = $signed({{(MULB_W-C_W){1'b0}}, decay_reg[CIDX_W'(r_reg)]});
            end
            default: begin
                mul_a = recent_reg[r_reg];
                mul_b = MULB_W'(d_reg[r_reg]);
            end
        endcase
    end

    assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

    // sequencer and datapath next values
    always_comb begin
        logic [POS_W-1:0]     pos_now;
        logic [CMP_W-1:0]     pos_c, n_c, t1_c, t2_c, k_c;
        logic [DIVR_W:0]      trial, diff;
        logic                 qbit;
        logic [GAIN_W-1:0]    quot;
        logic signed [SUM_W-1:0] sum;
        logic signed [ACC_W-1:0] ar;
        logic [ACC_W-OUT_SH-SAMPLE_W:0] top;

        state_next           = state_reg;
        r_next               = r_reg;
        period_position_next = period_position_reg;
        pos_next             = pos_reg;
        n_next               = n_reg;
        b_next               = b_reg;
        d_next               = d_reg;
        recent_next          = recent_reg;
        older_next           = older_reg;
        decay_next           = decay_reg;
        gain_next            = gain_reg;
        shape_next           = shape_reg;
        x_next               = x_reg;
        k_next               = k_reg;
        div_next             = div_reg;
        falling_next         = falling_reg;
        num_next             = num_reg;
        rem_next             = rem_reg;
        cnt_next             = cnt_reg;
        prod_next            = prod_reg;
        t1_next              = t1_reg;
        acc_next             = acc_reg;
        m_valid_next         = m_valid_reg;
        m_sample_next        = m_sample_reg;

        pos_now = '0;
        pos_c   = CMP_W'(pos_reg);
        n_c     = CMP_W'(n_reg);
        t1_c    = n_c >> 2;
        t2_c    = n_c >> 1;
        k_c     = '0;
        trial   = {rem_reg, num_reg[DIVN_W-1]};
        diff    = trial - {1'b0, div_reg};
        qbit    = 1'b0;
        quot    = '0;
        sum     = '0;
        ar      = acc_reg + OUT_HALF;
        top     = ar[ACC_W-1:OUT_SH+SAMPLE_W-1];

        // register writes
        if (cfg_valid) begin
            case (cfg_index)
                REG_DECAY_FIRST:   decay_next[0] = cfg_data[C_W-1:0];
                REG_DECAY_SECOND:  decay_next[1] = cfg_data[C_W-1:0];
                REG_DECAY_THIRD:   decay_next[2] = cfg_data[C_W-1:0];
                REG_DECAY_FOURTH:  decay_next[3] = cfg_data[C_W-1:0];
                REG_PULSE_GAIN:    gain_next     = cfg_data[GAIN_W-1:0];
                REG_GLOTTAL_SHAPE: shape_next    = cfg_data[0];
                default: ;
            endcase
        end

        // output register drains independently of the sequencer
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    pos_now  = s_period_start ? '0 : period_position_reg;
                    pos_next = pos_now;
                    period_position_next = (pos_now == POS_W'(MAX_PERIOD)) ?
                                           POS_W'(MAX_PERIOD) : pos_now + 1'b1;
                    n_next   = s_period_length;
                    for (int i = 0; i < ACTIVE; i++) begin
                        b_next[i] = b_in[i];
                        d_next[i] = d_in[i];
                    end
                    acc_next   = '0;
                    state_next = S_EXC;
                end
            end

            // excitation: impulse, or pick the triangle slope to divide
            S_EXC: begin
                r_next     = '0;
                state_next = S_RB;
                if (shape_reg == SHAPE_IMPULSE) begin
                    x_next = (pos_reg == '0) ? gain_reg : '0;
                end else if (pos_c >= n_c) begin
                    x_next = '0;
                end else if (pos_c <= t1_c) begin
                    if (t1_c == '0) begin
                        x_next = gain_reg;
                    end else begin
                        k_next       = pos_c[K_W-1:0];
                        div_next     = t1_c[DIVR_W-1:0];
                        falling_next = 1'b0;
                        state_next   = S_GMUL;
                    end
                end else if ((pos_c < t1_c + t2_c) && (t2_c != '0)) begin
                    k_c          = pos_c - t1_c;
                    k_next       = k_c[K_W-1:0];
                    div_next     = t2_c[DIVR_W-1:0];
                    falling_next = 1'b1;
                    state_next   = S_GMUL;
                end else begin
                    x_next = '0;
                end
            end

            // dividend gain*k straight into the divider
            S_GMUL: begin
                num_next   = mul_p[DIVN_W-1:0];
                rem_next   = '0;
                cnt_next   = '0;
                state_next = S_DIV;
            end

            // restoring division, one quotient bit per cycle
            S_DIV: begin
                if (trial >= {1'b0, div_reg}) begin
                    rem_next = diff[DIVR_W-1:0];
                    qbit     = 1'b1;
                end else begin
                    rem_next = trial[DIVR_W-1:0];
                end
                num_next = {num_reg[DIVN_W-2:0], qbit};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == DCNT_W'(DIVN_W - 1)) begin
                    quot       = num_next[GAIN_W-1:0];
                    x_next     = falling_reg ? gain_reg - quot : quot;
                    state_next = S_RB;
                end
            end

            // B * recent
            S_RB: begin
                prod_next  = mul_p;
                state_next = S_RC;
            end

            // C * older
            S_RC: begin
                t1_next    = rnd16(prod_reg);
                prod_next  = mul_p;
                state_next = S_RN;
            end

            // new state, shift the delay line, D * (new older)
            S_RN: begin
                sum = SUM_W'(t1_reg) - SUM_W'(rnd16(prod_reg))
                    + SUM_W'($signed({1'b0, x_reg}));
                if (!((&sum[SUM_W-1:STATE_W-1]) || !(|sum[SUM_W-1:STATE_W-1]))) begin
                    recent_next[r_reg] = sum[SUM_W-1] ? $signed({1'b1, {(STATE_W-1){1'b0}}})
                                                      : $signed({1'b0, {(STATE_W-1){1'b1}}});
                end else begin
                    recent_next[r_reg] = sum[STATE_W-1:0];
                end
                older_next[r_reg] = recent_reg[r_reg];
                prod_next         = mul_p;
                state_next        = S_RA;
            end

            // accumulate and step to the next resonator
            S_RA: begin
                acc_next = acc_reg + ACC_W'(prod_reg);
                if (r_reg == RIDX_W'(ACTIVE - 1)) begin
                    state_next = S_OUT;
                end else begin
                    r_next     = r_reg + 1'b1;
                    state_next = S_RB;
                end
            end

            // round, saturate and hand over to the output register
            S_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    if ((&top) || !(|top)) begin
                        m_sample_next = ar[OUT_SH+SAMPLE_W-1:OUT_SH];
                    end else begin
                        m_sample_next = ar[ACC_W-1] ? $signed({1'b1, {(SAMPLE_W-1){1'b0}}})
                                                    : $signed({1'b0, {(SAMPLE_W-1){1'b1}}});
                    end
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge aclk) begin
        pos_reg      <= pos_next;
        n_reg        <= n_next;
        b_reg        <= b_next;
        d_reg        <= d_next;
        x_reg        <= x_next;
        k_reg        <= k_next;
        div_reg      <= div_next;
        falling_reg  <= falling_next;
        num_reg      <= num_next;
        rem_reg      <= rem_next;
        cnt_reg      <= cnt_next;
        prod_reg     <= prod_next;
        t1_reg       <= t1_next;
        acc_reg      <= acc_next;
        m_sample_reg <= m_sample_next;
        if (!aresetn) begin
            state_reg           <= S_IDLE;
            r_reg               <= '0;
            period_position_reg <= '0;
            decay_reg           <= DECAY_RST;
            gain_reg            <= GAIN_RST;
            shape_reg           <= SHAPE_RST;
            m_valid_reg         <= 1'b0;
            for (int i = 0; i < ACTIVE; i++) begin
                recent_reg[i] <= '0;
                older_reg[i]  <= '0;
            end
        end else begin
            state_reg           <= state_next;
            r_reg               <= r_next;
            period_position_reg <= period_position_next;
            decay_reg           <= decay_next;
            gain_reg            <= gain_next;
            shape_reg           <= shape_next;
            m_valid_reg         <= m_valid_next;
            recent_reg          <= recent_next;
            older_reg           <= older_next;
        end
    end

    // position counter saturates at the longest period
    assert property (@(posedge aclk) disable iff (!aresetn)
        period_position_reg <= POS_W'(MAX_PERIOD))
        else $error("period position beyond its limit");

    // an accepted item keeps the block busy in the next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("ready again straight after an item");

    // resonator index stays within the active resonators
    assert property (@(posedge aclk) disable iff (!aresetn)
        r_reg <= RIDX_W'(ACTIVE - 1))
        else $error("resonator index out of range");

    // divider remainder stays below the divisor
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DIV) |-> (rem_reg < div_reg))
        else $error("divider remainder not below divisor");

    // a result only appears out of the final step
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == S_OUT))
        else $error("result raised outside the output step");

endmodule
